/* rtl/fwrk_pkg.sv */
// shared types and constants for the wait queue with remove by key
package fwrk_pkg;

  localparam int ID_W        = 31;
  localparam int LIMIT_W     = 5;
  localparam int COUNT_OUT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DROP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_HEAD_RD  = 3'd1,
    S_HEAD_CAP = 3'd2,
    S_SCAN_RD  = 3'd3,
    S_SCAN_CMP = 3'd4,
    S_SHIFT_RD = 3'd5,
    S_SHIFT_WR = 3'd6,
    S_DONE     = 3'd7
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] rid;
    status_t         status;
  } res_t;

endpackage

/* rtl/fwrk_ram.sv */
// generic single write port ram with registered read
module fwrk_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/fwrk_seq.sv */
// sequencer: append, head pop, key scan and compacting shift over the entry ram
module fwrk_seq #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  fwrk_pkg::op_t                    in_op,
  input  logic [fwrk_pkg::ID_W-1:0]        in_id,
  output logic                             in_ready,
  input  logic                             res_ready,
  output logic                             res_valid,
  output fwrk_pkg::res_t                   res,
  output logic [$clog2(DEPTH+1)-1:0]       count,
  output logic                             ram_we,
  output logic [$clog2(DEPTH)-1:0]         ram_waddr,
  output logic [fwrk_pkg::ID_W-1:0]        ram_wdata,
  output logic [$clog2(DEPTH)-1:0]         ram_raddr,
  input  logic [fwrk_pkg::ID_W-1:0]        ram_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fwrk_pkg::state_t          state_r, state_nxt;
  fwrk_pkg::op_t             op_r, op_nxt;
  logic [fwrk_pkg::ID_W-1:0] key_r, key_nxt;
  logic [fwrk_pkg::ID_W-1:0] rid_r, rid_nxt;
  fwrk_pkg::status_t         status_r, status_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      second_r, second_nxt;

  logic [CW-1:0] idx_plus;
  logic          is_full;
  logic          is_empty;
  logic          more;
  logic          scan_last;
  logic          hit;
  logic          promote;

  assign idx_plus  = CW'(idx_r) + CW'(1);
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign more      = (idx_plus < count_r);
  assign scan_last = (idx_plus == count_r);
  assign hit       = (ram_rdata == key_r);
  // drop and promote takes the head a second time if anything is left
  assign promote   = (op_r == fwrk_pkg::OP_DROP) && !second_r && (count_r > CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fwrk_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    rid_r    <= rid_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    second_r <= second_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fwrk_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            fwrk_pkg::OP_APPEND: state_nxt = fwrk_pkg::S_DONE;
            fwrk_pkg::OP_REMOVE: state_nxt = is_empty ? fwrk_pkg::S_DONE : fwrk_pkg::S_SCAN_RD;
            fwrk_pkg::OP_POP,
            fwrk_pkg::OP_DROP:   state_nxt = is_empty ? fwrk_pkg::S_DONE : fwrk_pkg::S_HEAD_RD;
          endcase
        end
      end
      fwrk_pkg::S_HEAD_RD:  state_nxt = fwrk_pkg::S_HEAD_CAP;
      fwrk_pkg::S_HEAD_CAP: state_nxt = fwrk_pkg::S_SHIFT_RD;
      fwrk_pkg::S_SCAN_RD:  state_nxt = fwrk_pkg::S_SCAN_CMP;
      fwrk_pkg::S_SCAN_CMP: begin
        if (hit) begin
          state_nxt = fwrk_pkg::S_SHIFT_RD;
        end else if (scan_last) begin
          state_nxt = fwrk_pkg::S_DONE;
        end else begin
          state_nxt = fwrk_pkg::S_SCAN_RD;
        end
      end
      fwrk_pkg::S_SHIFT_RD: begin
        if (more) begin
          state_nxt = fwrk_pkg::S_SHIFT_WR;
        end else if (promote) begin
          state_nxt = fwrk_pkg::S_HEAD_RD;
        end else begin
          state_nxt = fwrk_pkg::S_DONE;
        end
      end
      fwrk_pkg::S_SHIFT_WR: state_nxt = fwrk_pkg::S_SHIFT_RD;
      fwrk_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = fwrk_pkg::S_IDLE;
        end
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    op_nxt     = op_r;
    key_nxt    = key_r;
    rid_nxt    = rid_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    second_nxt = second_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = ram_rdata;
    ram_raddr  = idx_r;
    unique case (state_r)
      fwrk_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          key_nxt    = in_id;
          rid_nxt    = '0;
          status_nxt = fwrk_pkg::ST_OK;
          idx_nxt    = '0;
          second_nxt = 1'b0;
          if (in_op == fwrk_pkg::OP_APPEND) begin
            if (is_full) begin
              status_nxt = fwrk_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_r[AW-1:0];
              ram_wdata = in_id;
              count_nxt = count_r + CW'(1);
              rid_nxt   = in_id;
            end
          end else if (is_empty) begin
            status_nxt = fwrk_pkg::ST_EMPTY;
          end
        end
      end
      fwrk_pkg::S_HEAD_RD: begin
        ram_raddr = '0;
        idx_nxt   = '0;
      end
      fwrk_pkg::S_HEAD_CAP: begin
        rid_nxt = ram_rdata;
      end
      fwrk_pkg::S_SCAN_RD: begin
        ram_raddr = idx_r;
      end
      fwrk_pkg::S_SCAN_CMP: begin
        if (hit) begin
          rid_nxt = key_r;
        end else if (scan_last) begin
          status_nxt = fwrk_pkg::ST_NOT_FOUND;
        end else begin
          idx_nxt = idx_plus[AW-1:0];
        end
      end
      fwrk_pkg::S_SHIFT_RD: begin
        if (more) begin
          ram_raddr = idx_plus[AW-1:0];
        end else begin
          count_nxt = count_r - CW'(1);
          if (promote) begin
            second_nxt = 1'b1;
          end
        end
      end
      fwrk_pkg::S_SHIFT_WR: begin
        // close the gap one cell at a time
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_plus[AW-1:0];
      end
      fwrk_pkg::S_DONE: begin
      end
    endcase
  end

  assign in_ready   = (state_r == fwrk_pkg::S_IDLE);
  assign res_valid  = (state_r == fwrk_pkg::S_DONE);
  assign res.rid    = rid_r;
  assign res.status = status_r;
  assign count      = count_r;

endmodule

/* rtl/fifo_with_remove_by_key_unit.sv */
// top level of the ordered wait queue with remove by key
//
//   channel   direction  fields (lowest bit first)
//   in_*      slave      tuser: op[1:0]; tdata: student_id[30:0], pad[31]
//   out_*     master     tdata: result_id[30:0], status[32:31], entry_count[37:33],
//                               full_flag[38], empty_flag[39]
//   cfg_*     write      wdata: class_limit[4:0]
//
// step by step: append and any op on an empty queue go straight to the result; pop
// reads and captures the head, then shifts each later entry down one cell, a read
// and then a write per cell; drop-and-promote repeats this when more than one entry
// was held; remove by key reads and compares cells in order, then shifts on a hit.
// reset clears the entry count and the output valid; the ram is not cleared.
// in_tready is low from accept until the result has moved to the output register.
module fifo_with_remove_by_key_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // op[1:0]
  input  logic [31:0] in_tdata,   // student_id[30:0], zero pad[31]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_id, status, entry_count, full_flag, empty_flag
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata   // class_limit[4:0]
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > fwrk_pkg::LIMIT_W) ? CW : fwrk_pkg::LIMIT_W;

  logic [fwrk_pkg::LIMIT_W-1:0] limit_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [39:0]                  out_data_r, out_data_nxt;

  logic                      res_ready;
  logic                      res_valid;
  fwrk_pkg::res_t            res;
  logic [CW-1:0]             count;
  logic                      full_flag;
  logic                      empty_flag;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [fwrk_pkg::ID_W-1:0] ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [fwrk_pkg::ID_W-1:0] ram_rdata;

  fwrk_ram #(
    .WIDTH (fwrk_pkg::ID_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fwrk_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (fwrk_pkg::op_t'(in_tuser)),
    .in_id     (in_tdata[fwrk_pkg::ID_W-1:0]),
    .in_ready  (in_tready),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .count     (count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  assign res_ready  = !out_valid_r || out_tready;
  assign full_flag  = (LW'(count) == LW'(limit_r));
  assign empty_flag = (count == '0);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {empty_flag, full_flag, fwrk_pkg::COUNT_OUT_W'(count),
                       res.status, res.rid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= fwrk_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* sim/fifo_with_remove_by_key_checker.sv */
// watches the queue channels, predicts each result word and compares it field by field
module fifo_with_remove_by_key_checker
  import fwrk_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output int unsigned owed_count,
  output int unsigned fail_count
);

  typedef struct packed {
    logic [ID_W-1:0]        rid;
    status_t                status;
    logic [COUNT_OUT_W-1:0] count;
    logic                   full;
    logic                   empty;
  } queue_result_t;

  logic [ID_W-1:0]    roster[$];
  logic [LIMIT_W-1:0] class_limit;
  queue_result_t      owed_results[$];

  // applies one request to the roster and works out the word it yields
  function automatic queue_result_t serve_request(op_t op, logic [ID_W-1:0] id);
    queue_result_t r;
    int            i;
    r.rid    = '0;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (roster.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          roster.push_back(id);
          r.rid = id;
        end
      end
      OP_POP: begin
        if (roster.size() == 0) r.status = ST_EMPTY;
        else r.rid = roster.pop_front();
      end
      OP_REMOVE: begin
        if (roster.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          i = 0;
          while (i < roster.size() && roster[i] != id) i++;
          if (i < roster.size()) begin
            r.rid = roster[i];
            roster.delete(i);
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
      end
      default: begin
        // drop the head, then hand back the next one if there is one
        if (roster.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.rid = roster.pop_front();
          if (roster.size() > 0) r.rid = roster.pop_front();
        end
      end
    endcase
    r.count = COUNT_OUT_W'(roster.size());
    r.full  = (roster.size() == int'(class_limit));
    r.empty = (roster.size() == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
    fail_count++;
    $display("mismatch on %s: got %0h, want %0h", field, got, want);
  endtask

  always @(posedge clk) begin : watch
    queue_result_t want;
    if (!rst_n) begin
      roster.delete();
      owed_results.delete();
      class_limit = LIMIT_RESET;
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("word with none owed", out_tdata[ID_W-1:0], '0);
        end else begin
          want = owed_results.pop_front();
          if (out_tdata[30:0] !== want.rid) begin
            report_mismatch("result_id", out_tdata[30:0], want.rid);
          end
          if (out_tdata[32:31] !== want.status) begin
            report_mismatch("status", ID_W'(out_tdata[32:31]), ID_W'(want.status));
          end
          if (out_tdata[37:33] !== want.count) begin
            report_mismatch("entry_count", ID_W'(out_tdata[37:33]), ID_W'(want.count));
          end
          if (out_tdata[38] !== want.full) begin
            report_mismatch("full_flag", ID_W'(out_tdata[38]), ID_W'(want.full));
          end
          if (out_tdata[39] !== want.empty) begin
            report_mismatch("empty_flag", ID_W'(out_tdata[39]), ID_W'(want.empty));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        owed_results.push_back(serve_request(op_t'(in_tuser), in_tdata[ID_W-1:0]));
      end
      if (cfg_we) class_limit = cfg_wdata;
    end
    owed_count = owed_results.size();
  end

endmodule

/* sim/fifo_with_remove_by_key_unit_tb.sv */
// stimulus and verdict for the wait queue with remove by key
module fifo_with_remove_by_key_unit_tb;
  import fwrk_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int QUIET_CYCLES = 80;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [ID_W-1:0] ID_MAX = '1;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // op[1:0]
  logic [31:0] in_tdata;   // student_id[30:0], zero pad[31]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // result_id, status, entry_count, full_flag, empty_flag
  logic        cfg_we;
  logic [4:0]  cfg_wdata;  // class_limit[4:0]

  int unsigned owed_count;
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_asks;
  int unsigned hold_taken;
  int unsigned hold_left;
  int unsigned cycle_count;
  bit          fill_mode;
  logic [ID_W-1:0] recent_ids[$];

  fifo_with_remove_by_key_unit #(.DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  fifo_with_remove_by_key_checker #(.DEPTH(DEPTH)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .owed_count (owed_count),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  initial begin
    out_tready = 1'b0;
    hold_taken = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_taken != hold_asks) begin
        hold_taken = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fifo_with_remove_by_key_unit regression: fail");
    $finish;
  end

  // returns at the falling edge after the word was taken, valid still high
  task automatic send_request(op_t op, logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {1'b0, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    int unsigned b;
    r = $urandom_range(99);
    b = $urandom_range(ID_W - 1);
    if (r < 45) return ID_W'($urandom_range(1, 6));  // small pool so duplicates occur
    if (r < 70) return ID_W'($urandom);
    if (r < 80) return ($urandom_range(1) != 0) ? ID_MAX : '0;
    if (r < 90) return ID_W'(1) << b;
    return ID_MAX ^ (ID_W'(1) << b);
  endfunction

  function automatic logic [ID_W-1:0] pick_key();
    if (recent_ids.size() > 0 && $urandom_range(99) < 65) begin
      return recent_ids[$urandom_range(recent_ids.size() - 1)];
    end
    return pick_id();
  endfunction

  // fill runs push the queue toward full, drain runs pull it back toward empty
  function automatic op_t pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (fill_mode) begin
      if (r < 75) return OP_APPEND;
      if (r < 83) return OP_POP;
      if (r < 95) return OP_REMOVE;
      return OP_DROP;
    end
    if (r < 20) return OP_APPEND;
    if (r < 50) return OP_POP;
    if (r < 80) return OP_REMOVE;
    return OP_DROP;
  endfunction

  task automatic run_random(int n);
    int              k;
    int              run_left;
    op_t             op;
    logic [ID_W-1:0] id;
    run_left = 0;
    for (k = 0; k < n; k++) begin
      if (run_left == 0) begin
        fill_mode = !fill_mode;
        run_left  = $urandom_range(25, 50);
      end
      run_left--;
      op = pick_op();
      id = (op == OP_REMOVE) ? pick_key() : pick_id();
      if (op == OP_APPEND) begin
        recent_ids.push_back(id);
        if (recent_ids.size() > 24) void'(recent_ids.pop_front());
      end
      send_request(op, id);
    end
    settle();
  endtask

  initial begin
    in_tvalid     = 1'b0;
    in_tuser      = OP_APPEND;
    in_tdata      = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asks     = 0;
    fill_mode     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // empty queue cases
    send_request(OP_POP, '0);
    send_request(OP_DROP, ID_MAX);
    send_request(OP_REMOVE, 31'd5);
    // extremes and a duplicate, then a miss, first-match remove and a middle remove
    send_request(OP_APPEND, '0);
    send_request(OP_APPEND, ID_MAX);
    send_request(OP_APPEND, 31'd5);
    send_request(OP_APPEND, 31'd5);
    send_request(OP_APPEND, 31'd9);
    send_request(OP_REMOVE, 31'd1234);
    send_request(OP_REMOVE, 31'd5);
    send_request(OP_REMOVE, ID_MAX);
    // drop with a successor, then drop of the only entry
    send_request(OP_DROP, '0);
    send_request(OP_DROP, '0);
    send_request(OP_APPEND, 31'h2AAAAAAA);
    send_request(OP_APPEND, 31'h55555555);
    send_request(OP_POP, '0);
    send_request(OP_POP, '0);
    settle();

    // full flag at a limit of one, appends carry on past it
    set_limit(5'd1);
    send_request(OP_APPEND, 31'd7);
    send_request(OP_APPEND, 31'd8);
    send_request(OP_POP, '0);
    send_request(OP_POP, '0);
    settle();

    run_random(200);

    set_limit(5'd0);
    send_idle_pct = 73;
    run_random(200);

    // long hold-off so the output backs up and input stalls
    set_limit(5'd31);
    send_idle_pct = 0;
    stall_pct     = 73;
    hold_asks++;
    run_random(200);

    set_limit(5'd16);
    send_idle_pct = 12;
    stall_pct     = 12;
    run_random(200);

    set_limit(5'd9);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(200);

    set_limit(5'd17);
    send_idle_pct = 12;
    stall_pct     = 12;
    run_random(180);

    if (fail_count == 0) begin
      $display("fifo_with_remove_by_key_unit regression: pass");
    end else begin
      $display("fifo_with_remove_by_key_unit regression: fail");
    end
    $finish;
  end

endmodule
